// ===== sv/des_block_encrypt_unit_macros.svh =====
// Assertion macros shared by the DES encrypt unit
`ifndef DES_BLOCK_ENCRYPT_UNIT_MACROS_SVH
`define DES_BLOCK_ENCRYPT_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define DES_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("des assertion failed");

// check cons in the cycle after ante
`define DES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("des assertion failed");

`endif

// ===== sv/des_pkg.sv =====
// Types, tables and permutation functions of the DES encrypt unit
`timescale 1ns / 1ps
`default_nettype none
package des_pkg;

	localparam int BLK_W           = 64;
	localparam int KEY_W           = 64;
	localparam int HALF_W          = 32;
	localparam int SUB_W           = 48;
	localparam int CD_W            = 28;
	localparam int NR_W            = 5;
	localparam int CFG_IDX_W       = 2;
	localparam int DES_FULL_ROUNDS = 16;
	localparam int DES_MAX_ROUNDS  = 16;
	localparam logic [NR_W-1:0] NR_RESET = NR_W'(16);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CIPHER_KEY = 2'd0,
		CFG_NUM_ROUNDS = 2'd1
	} des_cfg_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0] cipher_key;
		logic [NR_W-1:0]  num_rounds;
	} des_cfg_t;

	typedef struct packed {
		logic [HALF_W-1:0] l;
		logic [HALF_W-1:0] r;
	} des_half_t;

	localparam logic [6:0] TAB_IP [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

	localparam logic [6:0] TAB_FP [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

	localparam logic [6:0] TAB_E [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
		28,29,30,31,32,1};

	localparam logic [6:0] TAB_P [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

	localparam logic [6:0] TAB_PC1 [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
		10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
		63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

	localparam logic [6:0] TAB_PC2 [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
		46,42,50,36,29,32};

	localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	localparam logic [3:0] TAB_S [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	function automatic des_half_t des_ip(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int i = 0; i < BLK_W; i++)
			r[BLK_W-1-i] = v[6'(7'd64 - TAB_IP[i])];
		return des_half_t'(r);
	endfunction

	function automatic logic [BLK_W-1:0] des_fp(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = '0;
		for (int i = 0; i < BLK_W; i++)
			r[BLK_W-1-i] = v[6'(7'd64 - TAB_FP[i])];
		return r;
	endfunction

	function automatic logic [CD_W-1:0] des_rot28(input logic [CD_W-1:0] x, input int s);
		logic [2*CD_W-1:0] t;
		t = {x, x} << s;
		return t[2*CD_W-1:CD_W];
	endfunction

	// subkey of round rnd (0-based): PC1, cumulative rotation, PC2
	function automatic logic [SUB_W-1:0] des_subkey(input logic [KEY_W-1:0] key,
		input int rnd);
		logic [2*CD_W-1:0] kp;
		logic [2*CD_W-1:0] cd;
		logic [SUB_W-1:0]  k;
		int                s;
		kp = '0;
		k  = '0;
		s  = 0;
		for (int i = 0; i < 56; i++)
			kp[55-i] = key[6'(7'd64 - TAB_PC1[i])];
		for (int i = 0; i < DES_FULL_ROUNDS; i++)
			if (i <= rnd)
				s = s + int'(TAB_ROT[i]);
		cd = {des_rot28(kp[2*CD_W-1:CD_W], s), des_rot28(kp[CD_W-1:0], s)};
		for (int i = 0; i < SUB_W; i++)
			k[SUB_W-1-i] = cd[6'(7'd56 - TAB_PC2[i])];
		return k;
	endfunction

	function automatic logic [HALF_W-1:0] des_feistel(input logic [HALF_W-1:0] r,
		input logic [SUB_W-1:0] k);
		logic [SUB_W-1:0]  x;
		logic [5:0]        b;
		logic [HALF_W-1:0] s;
		logic [HALF_W-1:0] p;
		x = '0;
		s = '0;
		p = '0;
		for (int i = 0; i < SUB_W; i++)
			x[SUB_W-1-i] = r[5'(7'd32 - TAB_E[i])];
		x = x ^ k;
		for (int j = 0; j < 8; j++) begin
			b = x[SUB_W-1-6*j -: 6];
			s[HALF_W-1-4*j -: 4] = TAB_S[j][{b[5], b[0], b[4:1]}];
		end
		for (int i = 0; i < HALF_W; i++)
			p[HALF_W-1-i] = s[5'(7'd32 - TAB_P[i])];
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== sv/des_in_if.sv =====
// Plaintext block channel
`timescale 1ns / 1ps
`default_nettype none
interface des_in_if
	import des_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] plain_block;

	modport source (output valid, output plain_block, input ready);
	modport sink (input valid, input plain_block, output ready);
endinterface
`default_nettype wire

// ===== sv/des_out_if.sv =====
// Ciphertext block channel
`timescale 1ns / 1ps
`default_nettype none
interface des_out_if
	import des_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [BLK_W-1:0] cipher_block;

	modport source (output valid, output cipher_block, input ready);
	modport sink (input valid, input cipher_block, output ready);
endinterface
`default_nettype wire

// ===== sv/des_cfg_if.sv =====
// Configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface des_cfg_if
	import des_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [KEY_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/des_block_encrypt_unit.sv =====
// DES ECB encrypt unit: IP, chain of round cells, IP^-1
// Usage:
//   blk_in  : valid/ready channel, one 64-bit plaintext block per item.
//   blk_out : valid/ready channel, one 64-bit ciphertext block per item.
//   cfg     : valid/ready write channel, index 0 = cipher key, index 1 = round
//             count (low 5 bits); other indexes are dropped. Always ready.
//             Write only while no item is in flight.
// Each accepted block is registered in every round cell in turn before it
// reaches blk_out. One round cell per stage, each cell holding one block and
// handing it on each cycle that the next cell is ready. Throughput is one item
// per cycle while the receiver does not stall. Rounds at or beyond the round
// count pass the block through unchanged; a count above MAX_ROUNDS acts as
// MAX_ROUNDS. Reset clears all cell valid bits, sets the key to zero and the
// round count to 16. When the receiver stalls, the last cell holds its item
// and the cells behind it keep advancing into empty places, so blk_in stays
// ready until every cell holds an item; then ready drops in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "des_block_encrypt_unit_macros.svh"
module des_block_encrypt_unit
	import des_pkg::*;
#(
	parameter int MAX_ROUNDS = DES_MAX_ROUNDS
) (
	input  wire        clk,
	input  wire        arst_n,
	des_in_if.sink     blk_in,
	des_out_if.source  blk_out,
	des_cfg_if.sink    cfg
);

	des_cfg_t  cfg_q;
	logic      stage_valid [MAX_ROUNDS+1];
	logic      stage_ready [MAX_ROUNDS+1];
	des_half_t stage_blk   [MAX_ROUNDS+1];
	logic      key_wr;
	logic      nr_wr;

	des_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	assign stage_valid[0] = blk_in.valid;
	assign blk_in.ready   = stage_ready[0];
	assign stage_blk[0]   = des_ip(blk_in.plain_block);

	for (genvar i = 0; i < MAX_ROUNDS; i++) begin : g_cell
		des_round_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cipher_key (cfg_q.cipher_key),
			.active     (cfg_q.num_rounds > NR_W'(i)),
			.in_valid   (stage_valid[i]),
			.in_ready   (stage_ready[i]),
			.in_blk     (stage_blk[i]),
			.out_valid  (stage_valid[i+1]),
			.out_ready  (stage_ready[i+1]),
			.out_blk    (stage_blk[i+1])
		);
	end

	assign blk_out.valid        = stage_valid[MAX_ROUNDS];
	assign stage_ready[MAX_ROUNDS] = blk_out.ready;
	assign blk_out.cipher_block = des_fp(stage_blk[MAX_ROUNDS]);

	assign key_wr = cfg.valid && cfg.ready && cfg.index == CFG_CIPHER_KEY;
	assign nr_wr  = cfg.valid && cfg.ready && cfg.index == CFG_NUM_ROUNDS;

	`DES_ASSERT_NEXT(a_in_to_cell, blk_in.valid && blk_in.ready, stage_valid[1])
	`DES_ASSERT_NEXT(a_key_write, key_wr, cfg_q.cipher_key == $past(cfg.data))
	`DES_ASSERT_NEXT(a_rounds_write, nr_wr, cfg_q.num_rounds == $past(cfg.data[NR_W-1:0]))
	`DES_ASSERT_SAME(a_ready_when_empty, !stage_valid[1], blk_in.ready)

endmodule
`default_nettype wire

// ===== sv/des_cfg_regs.sv =====
// Configuration registers: cipher key and round count
`timescale 1ns / 1ps
`default_nettype none
module des_cfg_regs
	import des_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	des_cfg_if.sink   cfg,
	output des_cfg_t  cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cipher_key <= '0;
			cfg_q.num_rounds <= NR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (des_cfg_idx_t'(cfg.index))
				CFG_CIPHER_KEY: cfg_q.cipher_key <= cfg.data;
				CFG_NUM_ROUNDS: cfg_q.num_rounds <= cfg.data[NR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/des_round_cell.sv =====
// One DES round cell with its own stage register
`timescale 1ns / 1ps
`default_nettype none
module des_round_cell
	import des_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire [KEY_W-1:0]  cipher_key,
	input  wire              active,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire des_half_t   in_blk,
	output logic             out_valid,
	input  wire              out_ready,
	output des_half_t        out_blk
);

	localparam bit SWAP = (IDX < DES_FULL_ROUNDS - 1);

	logic [SUB_W-1:0]  subkey;
	logic [HALF_W-1:0] new_r;
	des_half_t         blk_d;
	logic              valid_q;
	des_half_t         blk_q;

	assign subkey = des_subkey(cipher_key, IDX);
	assign new_r  = in_blk.l ^ des_feistel(in_blk.r, subkey);

	always_comb begin
		blk_d = in_blk;
		if (active) begin
			if (SWAP) begin
				blk_d.l = in_blk.r;
				blk_d.r = new_r;
			end else begin
				blk_d.l = new_r;
			end
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_blk   = blk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blk_q <= blk_d;
		end
	end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the DES ECB encrypt unit: random blocks, keys and round counts
`timescale 1ns / 1ps
module tb_top
	import des_pkg::*;
();

	localparam int PIPE_DEPTH = DES_MAX_ROUNDS;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	class cipher_ledger;
		logic [KEY_W-1:0] key;
		logic [NR_W-1:0]  rounds;
		logic [BLK_W-1:0] cipher_due[$];
		int               errors;
		int               blocks_in;
		int               blocks_out;

		function new();
			key        = '0;
			rounds     = NR_W'(16);
			errors     = 0;
			blocks_in  = 0;
			blocks_out = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
			if (idx == CFG_CIPHER_KEY)
				key = data;
			else if (idx == CFG_NUM_ROUNDS)
				rounds = data[NR_W-1:0];
		endfunction

		function logic [27:0] rotl28(logic [27:0] x, int s);
			logic [55:0] t;
			t = {x, x} << s;
			return t[55:28];
		endfunction

		function logic [SUB_W-1:0] pc2_select(logic [27:0] c, logic [27:0] d);
			logic [55:0]      cd;
			logic [SUB_W-1:0] k;
			cd = {c, d};
			for (int i = 0; i < SUB_W; i++)
				k[SUB_W-1-i] = cd[56 - int'(TAB_PC2[i])];
			return k;
		endfunction

		function logic [HALF_W-1:0] mangle(logic [HALF_W-1:0] r, logic [SUB_W-1:0] k);
			logic [SUB_W-1:0]  x;
			logic [5:0]        b;
			logic [HALF_W-1:0] s;
			logic [HALF_W-1:0] p;
			for (int i = 0; i < SUB_W; i++)
				x[SUB_W-1-i] = r[32 - int'(TAB_E[i])];
			x = x ^ k;
			for (int j = 0; j < 8; j++) begin
				b = x[SUB_W-1-6*j -: 6];
				s[HALF_W-1-4*j -: 4] = TAB_S[j][int'({b[5], b[0]}) * 16 + int'(b[4:1])];
			end
			for (int i = 0; i < HALF_W; i++)
				p[HALF_W-1-i] = s[32 - int'(TAB_P[i])];
			return p;
		endfunction

		function logic [BLK_W-1:0] cipher_of(logic [BLK_W-1:0] pt);
			logic [55:0]       kp;
			logic [27:0]       c;
			logic [27:0]       d;
			logic [BLK_W-1:0]  v;
			logic [HALF_W-1:0] l;
			logic [HALF_W-1:0] r;
			logic [HALF_W-1:0] nr;
			logic [BLK_W-1:0]  ct;
			int                n;
			for (int i = 0; i < 56; i++)
				kp[55-i] = key[64 - int'(TAB_PC1[i])];
			c = kp[55:28];
			d = kp[27:0];
			for (int i = 0; i < BLK_W; i++)
				v[BLK_W-1-i] = pt[64 - int'(TAB_IP[i])];
			l = v[63:32];
			r = v[31:0];
			n = (int'(rounds) > DES_MAX_ROUNDS) ? DES_MAX_ROUNDS : int'(rounds);
			for (int i = 0; i < n; i++) begin
				c  = rotl28(c, int'(TAB_ROT[i]));
				d  = rotl28(d, int'(TAB_ROT[i]));
				nr = l ^ mangle(r, pc2_select(c, d));
				if (i < 15) begin
					l = r;
					r = nr;
				end else begin
					l = nr;
				end
			end
			v = {l, r};
			for (int i = 0; i < BLK_W; i++)
				ct[BLK_W-1-i] = v[64 - int'(TAB_FP[i])];
			return ct;
		endfunction

		function void take_plain(logic [BLK_W-1:0] pt);
			cipher_due.push_back(cipher_of(pt));
			blocks_in++;
		endfunction

		function void match_cipher(logic [BLK_W-1:0] got);
			logic [BLK_W-1:0] want;
			blocks_out++;
			if (cipher_due.size() == 0) begin
				errors++;
				$display("%0t: cipher_block %h with no block pending", $time, got);
			end else begin
				want = cipher_due.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: cipher_block expected %h actual %h", $time, want, got);
				end
			end
		endfunction

		function int pending();
			return cipher_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	des_in_if  in_ch();
	des_out_if out_ch();
	des_cfg_if cfg_ch();

	des_block_encrypt_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.blk_in (in_ch),
		.blk_out(out_ch),
		.cfg    (cfg_ch)
	);

	cipher_ledger ledger;
	bit           tx_free;
	bit           rx_free;
	int           rx_hold;
	int           reg_writes;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 88)
			return $urandom_range(0, 3);
		return $urandom_range(8, 60);
	endfunction

	function automatic logic [BLK_W-1:0] pick_block();
		logic [BLK_W-1:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1: v = '1;
			2: v = BLK_W'(1) << $urandom_range(0, BLK_W - 1);
			3: v = ~(BLK_W'(1) << $urandom_range(0, BLK_W - 1));
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		ledger.set_reg(idx, data);
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_rounds(input int n);
		logic [KEY_W-1:0] data;
		data           = {$urandom, $urandom};
		data[NR_W-1:0] = NR_W'(n);
		set_reg(CFG_NUM_ROUNDS, data);
	endtask

	task automatic send_block(input logic [BLK_W-1:0] pt, input int gap);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.plain_block <= pt;
		do @(posedge clk); while (!in_ch.ready);
		ledger.take_plain(pt);
	endtask

	task automatic send_gapped(input logic [BLK_W-1:0] pt);
		send_block(pt, tx_free ? 0 : idle_len());
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 4) @(posedge clk);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				tx_free = ($urandom_range(0, 3) == 0);
				rx_free = ($urandom_range(0, 3) == 0);
			end
			send_gapped(pick_block());
		end
	endtask

	initial begin : rx_drive
		int run;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_ch.ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (rx_free) begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 24);
				out_ch.ready <= 1'b1;
				repeat (run) @(posedge clk);
				out_ch.ready <= 1'b0;
				repeat (idle_len() + 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			ledger.match_cipher(out_ch.cipher_block);

	initial begin
		#20ms;
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : main
		logic [KEY_W-1:0] k;
		int               n;
		ledger     = new();
		tx_free    = 1'b0;
		rx_free    = 1'b0;
		rx_hold    = 0;
		reg_writes = 0;
		arst_n            = 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.plain_block <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= CFG_CIPHER_KEY;
		cfg_ch.data       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero key, full rounds
		send_gapped(64'h0);
		send_gapped('1);
		send_gapped(64'h0123456789ABCDEF);
		drain();

		set_reg(CFG_CIPHER_KEY, 64'h133457799BBCDFF1);
		send_gapped(64'h0123456789ABCDEF);
		send_gapped(64'h0);
		send_gapped('1);
		send_gapped(64'h8000000000000000);
		send_gapped(64'h0000000000000001);
		send_gapped(64'hAAAAAAAAAAAAAAAA);
		send_gapped(64'h5555555555555555);
		drain();

		// writes to unused indexes must not disturb the settings
		set_reg(CFG_SPARE_2, '1);
		set_reg(CFG_SPARE_3, 64'h0000000000000003);
		send_gapped(64'h0123456789ABCDEF);
		drain();

		set_rounds(1);
		send_gapped(64'h0123456789ABCDEF);
		send_gapped('1);
		drain();
		set_rounds(0);
		send_gapped(64'h0123456789ABCDEF);
		send_gapped(64'hDEADBEEFCAFEF00D);
		drain();
		set_rounds(15);
		send_gapped(64'h0123456789ABCDEF);
		drain();
		set_rounds(31);
		send_gapped(64'h0123456789ABCDEF);
		drain();
		set_rounds(17);
		send_gapped(64'h0123456789ABCDEF);
		drain();
		set_reg(CFG_CIPHER_KEY, '1);
		set_rounds(16);
		send_gapped(64'h0);
		send_gapped('1);
		drain();
		set_reg(CFG_CIPHER_KEY, 64'h0101010101010101);
		send_gapped(64'h0123456789ABCDEF);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: k = (ph == 0) ? '0 : '1;
				default: k = {$urandom, $urandom};
			endcase
			case (ph)
				0: n = 16;
				1: n = 1;
				2: n = 16;
				3: n = 0;
				4: n = 31;
				5: n = $urandom_range(2, 15);
				default: n = $urandom_range(0, 31);
			endcase
			set_reg(CFG_CIPHER_KEY, k);
			set_rounds(n);
			if (ph == 2) begin
				// stall the output long enough for the input to back up
				tx_free = 1'b1;
				rx_hold = 200;
				for (int i = 0; i < 60; i++)
					send_block(pick_block(), 0);
				run_random(70);
			end else if (ph == 4) begin
				run_random(60);
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (ledger.pending() > 0)
					@(posedge clk);
				run_random(70);
			end else begin
				run_random(130);
			end
			drain();
		end

		$display("tb_top: %0d blocks in, %0d out, %0d register writes", ledger.blocks_in,
			ledger.blocks_out, reg_writes);
		$display("tb_top: keys zero, ones, weak and random; round counts 0, 1, 15, 16 and above");
		if (ledger.errors == 0 && ledger.pending() == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
